// File: rtl/core/ercv_pkg.sv
// ----------------------------------------------------------------------------
// ercv_pkg
// Shared widths and the request/response types of the serial divider used by
// the encoder reply check and velocity block.
// ----------------------------------------------------------------------------
package ercv_pkg;

  // field widths
  localparam int POS_W  = 14;
  localparam int VEL_W  = 24;
  localparam int TIME_W = 32;
  localparam int CNT_W  = 32;

  // |delta| * 1000 fits in 23 bits, so does the quotient
  localparam int DVD_W = 23;

  // default slot count
  localparam int ERCV_NUM_SLOTS = 4;

  // divider request from the sequencer
  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: rtl/core/ercv_div.sv
// ----------------------------------------------------------------------------
// ercv_div
// Restoring serial divider, one quotient bit per cycle. Divides the velocity
// numerator magnitude by the elapsed time in milliseconds.
// ----------------------------------------------------------------------------
module ercv_div
  import ercv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [TIME_W-1:0] rem_r;
  logic [TIME_W-1:0] dvs_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  quot_r;

  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   trial_diff;
  logic              trial_ge;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial      = {rem_r, dvd_r[DVD_W-1]};
    trial_diff = trial - {1'b0, dvs_r};
    trial_ge   = (trial >= {1'b0, dvs_r});
  end

  // iteration control and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DVD_W);
        rem_r  <= '0;
        dvs_r  <= req.divisor;
        dvd_r  <= req.dividend;
        quot_r <= '0;
      end else if (busy_r) begin
        rem_r  <= trial_ge ? trial_diff[TIME_W-1:0] : trial[TIME_W-1:0];
        quot_r <= {quot_r[DVD_W-2:0], trial_ge};
        dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// File: rtl/core/encoder_reply_check_and_velocity.sv
// ----------------------------------------------------------------------------
// encoder_reply_check_and_velocity
// Checks one polled absolute encoder reply per item, keeps per-slot position,
// velocity and read counters, and reports them in counts and in degrees.
// ----------------------------------------------------------------------------
// One item is taken at a time: in_tready is high only while the sequencer is
// idle. A slot not in use goes from S_EVAL to S_PACK, a reply needing no new
// velocity goes via S_MUL, and a good reply with nonzero elapsed time passes
// S_LOAD and S_DIV too, where the 23-step serial divider forms delta*1000/dt.
// The result sits in an output register, so the next item is accepted while
// it waits for out_tready. Position is unwrapped modulo 2^resolution before
// the velocity divide; a zero elapsed time keeps the previous velocity.
module encoder_reply_check_and_velocity
  import ercv_pkg::*;
#(
  parameter int NUM_SLOTS = ERCV_NUM_SLOTS
) (
  input  logic         clk,
  input  logic         rst_n,
  // input items
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // raw_reply[15:0], now_ms[47:16]
  input  logic [2:0]   in_tuser,   // slot[1:0], read_ok[2]
  // result items
  output logic         out_tvalid,
  input  logic         out_tready,
  // online[0], position_counts[14:1], velocity_counts[38:15],
  // position_tenths_deg[50:39], velocity_hundredths_deg[66:51],
  // good_reads[98:67], bad_reads[130:99], zero fill[135:131]
  output logic [135:0] out_tdata,
  output logic [4:0]   out_tuser,  // slot_out[1:0], accepted[2], reply_status[4:3]
  // configuration writes
  input  logic         cfg_we,
  input  logic [0:0]   cfg_addr,
  input  logic [3:0]   cfg_wdata
);

  localparam int SLOT_IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // register indexes
  localparam logic [0:0] REG_RESOLUTION = 1'd0;
  localparam logic [0:0] REG_ENC_COUNT  = 1'd1;

  // reply status codes
  localparam logic [1:0] ST_GOOD  = 2'd0;
  localparam logic [1:0] ST_XFER  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;

  // check bit coverage
  localparam logic [13:0] ODD_MASK  = 14'h2AAA;
  localparam logic [13:0] EVEN_MASK = 14'h1555;

  // scale factors
  localparam logic [9:0]  VEL_MS_SCALE = 10'd1000;
  localparam logic [15:0] HDEG_SCALE   = 16'd36000;
  localparam logic [11:0] TDEG_SCALE   = 12'd3600;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_LOAD,
    S_DIV,
    S_MUL,
    S_PACK
  } state_t;

  // configuration
  logic [3:0] res_cfg_r;
  logic [2:0] enc_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cfg_r <= 4'd14;
      enc_cnt_r <= 3'd4;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RESOLUTION: res_cfg_r <= cfg_wdata;
        REG_ENC_COUNT:  enc_cnt_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // effective resolution and derived counts per revolution
  logic [3:0]       res_eff;
  logic [3:0]       shamt;
  logic [POS_W:0]   cpr;
  logic [POS_W-1:0] pos_mask;

  always_comb begin
    if (res_cfg_r == 4'd0) begin
      res_eff = 4'd1;
    end else if (res_cfg_r > 4'd14) begin
      res_eff = 4'd14;
    end else begin
      res_eff = res_cfg_r;
    end
    shamt    = 4'd14 - res_eff;
    cpr      = (POS_W+1)'(1) << res_eff;
    pos_mask = POS_W'(cpr - (POS_W+1)'(1));
  end

  // per-slot state
  logic [POS_W-1:0]  pos_r  [NUM_SLOTS];
  logic [TIME_W-1:0] time_r [NUM_SLOTS];
  logic              has_r  [NUM_SLOTS];
  logic [VEL_W-1:0]  vel_r  [NUM_SLOTS];
  logic              onl_r  [NUM_SLOTS];
  logic [CNT_W-1:0]  good_r [NUM_SLOTS];
  logic [CNT_W-1:0]  bad_r  [NUM_SLOTS];

  // sequencer registers
  state_t            state_r;
  logic [1:0]        slot_r;
  logic              ok_r;
  logic [15:0]       reply_r;
  logic [TIME_W-1:0] now_r;
  logic              acc_r;
  logic [1:0]        status_r;
  logic [POS_W-1:0]  dmag_r;
  logic              dneg_r;
  logic [TIME_W-1:0] dt_r;
  logic              vneg_r;
  logic [38:0]       hprod_r;
  logic [25:0]       tprod_r;
  logic              out_tvalid_r;
  logic [135:0]      out_tdata_r;
  logic [4:0]        out_tuser_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // reply evaluation
  logic [SLOT_IW-1:0] sidx;
  logic               acc;
  logic [1:0]         status;
  logic [POS_W-1:0]   cur;
  logic [POS_W-1:0]   prev;
  logic [TIME_W-1:0]  dt;
  logic signed [15:0] diff;
  logic signed [15:0] half_s;
  logic signed [15:0] cpr_s;
  logic signed [15:0] delta;
  logic               wr_good;
  logic               wr_first;
  logic               wr_bad;
  logic               wr_vel;
  logic               need_div;
  logic [VEL_W-1:0]   vel_new;

  always_comb begin
    sidx = SLOT_IW'(slot_r);
    acc  = ({1'b0, slot_r} < enc_cnt_r) && (32'(slot_r) < 32'(NUM_SLOTS));
    if (!ok_r) begin
      status = ST_XFER;
    end else if ((reply_r[15] == ~(^(reply_r[13:0] & ODD_MASK))) &&
                 (reply_r[14] == ~(^(reply_r[13:0] & EVEN_MASK)))) begin
      status = ST_GOOD;
    end else begin
      status = ST_CHECK;
    end
    cur    = POS_W'(reply_r[13:0] >> shamt);
    prev   = pos_r[sidx] & pos_mask;
    dt     = now_r - time_r[sidx];
    diff   = $signed({2'b00, cur}) - $signed({2'b00, prev});
    half_s = $signed({1'b0, cpr >> 1});
    cpr_s  = $signed({1'b0, cpr});
    // wrap the position change into half a revolution either way
    if (diff > half_s) begin
      delta = diff - cpr_s;
    end else if (diff < -half_s) begin
      delta = diff + cpr_s;
    end else begin
      delta = diff;
    end
  end

  // state file write strobes
  always_comb begin
    wr_good  = (state_r == S_EVAL) && acc && (status == ST_GOOD);
    wr_bad   = (state_r == S_EVAL) && acc && (status != ST_GOOD);
    wr_first = wr_good && !has_r[sidx];
    need_div = wr_good && has_r[sidx] && (dt != '0);
    wr_vel   = (state_r == S_DIV) && div_rsp.done;
    vel_new  = dneg_r ? (VEL_W'(0) - VEL_W'(div_rsp.quot)) : VEL_W'(div_rsp.quot);
  end

  // per-slot state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        pos_r[i]  <= '0;
        time_r[i] <= '0;
        has_r[i]  <= 1'b0;
        vel_r[i]  <= '0;
        onl_r[i]  <= 1'b0;
        good_r[i] <= '0;
        bad_r[i]  <= '0;
      end
    end else begin
      if (wr_good) begin
        onl_r[sidx]  <= 1'b1;
        good_r[sidx] <= good_r[sidx] + CNT_W'(1);
        pos_r[sidx]  <= cur;
        time_r[sidx] <= now_r;
      end
      if (wr_first) begin
        vel_r[sidx] <= '0;
        has_r[sidx] <= 1'b1;
      end
      if (wr_bad) begin
        onl_r[sidx] <= 1'b0;
        bad_r[sidx] <= bad_r[sidx] + CNT_W'(1);
      end
      if (wr_vel) begin
        vel_r[sidx] <= vel_new;
      end
    end
  end

  // divider request
  always_comb begin
    div_req.start    = (state_r == S_LOAD);
    div_req.dividend = DVD_W'(24'(dmag_r) * 24'(VEL_MS_SCALE));
    div_req.divisor  = dt_r;
  end

  ercv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // conversion of the stored state for the result
  logic [VEL_W-1:0] vel_cur;
  logic [DVD_W-1:0] vmag;
  logic [38:0]      hmag;
  logic [15:0]      hdeg;
  logic [11:0]      tdeg;

  always_comb begin
    vel_cur = vel_r[sidx];
    vmag    = DVD_W'(vel_cur[VEL_W-1] ? (VEL_W'(0) - vel_cur) : vel_cur);
    hmag    = hprod_r >> res_eff;
    if (vneg_r) begin
      hdeg = (hmag > 39'd32768) ? 16'h8000 : (16'd0 - hmag[15:0]);
    end else begin
      hdeg = (hmag > 39'd32767) ? 16'h7FFF : hmag[15:0];
    end
    tdeg = 12'(tprod_r >> res_eff);
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if ((state_r == S_PACK) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            slot_r  <= in_tuser[1:0];
            ok_r    <= in_tuser[2];
            reply_r <= in_tdata[15:0];
            now_r   <= in_tdata[47:16];
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          acc_r    <= acc;
          status_r <= status;
          dmag_r   <= POS_W'(delta[15] ? -delta : delta);
          dneg_r   <= delta[15];
          dt_r     <= dt;
          if (!acc) begin
            state_r <= S_PACK;
          end else if (need_div) begin
            state_r <= S_LOAD;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_LOAD: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          vneg_r  <= vel_cur[VEL_W-1];
          hprod_r <= 39'(vmag) * 39'(HDEG_SCALE);
          tprod_r <= 26'(pos_r[sidx] & pos_mask) * 26'(TDEG_SCALE);
          state_r <= S_PACK;
        end
        S_PACK: begin
          if (!out_tvalid_r || out_tready) begin
            if (acc_r) begin
              out_tuser_r <= {status_r, 1'b1, slot_r};
              out_tdata_r <= {5'd0, bad_r[sidx], good_r[sidx], hdeg, tdeg,
                              vel_cur, pos_r[sidx], onl_r[sidx]};
            end else begin
              out_tuser_r <= {ST_GOOD, 1'b0, slot_r};
              out_tdata_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  // the divider only runs while the sequencer waits on it
  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> (state_r == S_DIV))
    else $error("divider busy outside the divide step");

  // a rejected slot reports nothing but its index
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[2]) |-> ((out_tdata == '0) && (out_tuser[4:3] == ST_GOOD)))
    else $error("rejected slot result carries data");

  // a good reply leaves the slot online
  a_good_online: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2] && (out_tuser[4:3] == ST_GOOD)) |-> out_tdata[0])
    else $error("good reply but slot offline");

  // a failed or bad reply leaves the slot offline
  a_bad_offline: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2] && (out_tuser[4:3] != ST_GOOD)) |-> !out_tdata[0])
    else $error("bad reply but slot online");
`endif

endmodule
